FILE: sv/td_pkg.sv
// Shared types, constants and register codes for the touch dip detector.
`default_nettype none

package td_pkg;

   // Channel count and field widths
   localparam int unsigned TD_CHANNELS       = 2;
   localparam int unsigned TD_MAX_CHANNELS   = 2;
   localparam int unsigned TD_SAMPLE_BITS    = 10;
   localparam int unsigned TD_LEVEL_BITS     = 5;
   localparam int unsigned TD_MARGIN_BITS    = 8;
   localparam int unsigned TD_TICK_BITS      = 8;
   localparam int unsigned TD_CSR_INDEX_BITS = 3;
   localparam int unsigned TD_CSR_DATA_BITS  = 8;

   typedef logic [TD_SAMPLE_BITS-1:0]    td_sample_type;
   typedef logic [TD_LEVEL_BITS-1:0]     td_level_type;
   typedef logic [TD_MARGIN_BITS-1:0]    td_margin_type;
   typedef logic [TD_TICK_BITS-1:0]      td_tick_type;
   typedef logic [TD_CSR_INDEX_BITS-1:0] td_csr_index_type;
   typedef logic [TD_CSR_DATA_BITS-1:0]  td_csr_data_type;

   // Register indexes on the configuration port
   typedef enum logic [TD_CSR_INDEX_BITS-1:0] {
      TD_REG_DROP_MARGIN  = 3'd0,
      TD_REG_COUNT_LIMIT  = 3'd1,
      TD_REG_ON_LEVEL     = 3'd2,
      TD_REG_OFF_LEVEL    = 3'd3,
      TD_REG_DECAY_PERIOD = 3'd4
   } td_reg_type;

   // Reset values of the registers
   localparam td_margin_type TD_RST_DROP_MARGIN  = 8'd15;
   localparam td_level_type  TD_RST_COUNT_LIMIT  = 5'd25;
   localparam td_level_type  TD_RST_ON_LEVEL     = 5'd15;
   localparam td_level_type  TD_RST_OFF_LEVEL    = 5'd10;
   localparam td_tick_type   TD_RST_DECAY_PERIOD = 8'd20;

   typedef struct packed {
      td_margin_type drop_margin;
      td_level_type  count_limit;
      td_level_type  on_level;
      td_level_type  off_level;
      td_tick_type   decay_period;
   } td_cfg_type;

   // Per-transaction control shared by all channels
   typedef struct packed {
      logic advance;
      logic decay;
      logic reload;
   } td_step_type;

   // Updated channel state, as reported in the result
   typedef struct packed {
      logic          touch;
      td_sample_type peak;
      td_level_type  level;
   } td_chan_out_type;

endpackage

`default_nettype wire

FILE: sv/td_csr.sv
// Configuration register file of the touch dip detector.
`default_nettype none

module td_csr (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output      logic                     csr_ready,
   input  wire td_pkg::td_csr_index_type csr_index,
   input  wire td_pkg::td_csr_data_type  csr_data,
   output      td_pkg::td_cfg_type       cfg
);
   import td_pkg::*;

   td_cfg_type cfg_ff;
   td_cfg_type cfg_in;

   // Always able to take a write
   assign csr_ready = 1'b1;

   // Decode the register index; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            TD_REG_DROP_MARGIN:  cfg_in.drop_margin  = csr_data[TD_MARGIN_BITS-1:0];
            TD_REG_COUNT_LIMIT:  cfg_in.count_limit  = csr_data[TD_LEVEL_BITS-1:0];
            TD_REG_ON_LEVEL:     cfg_in.on_level     = csr_data[TD_LEVEL_BITS-1:0];
            TD_REG_OFF_LEVEL:    cfg_in.off_level    = csr_data[TD_LEVEL_BITS-1:0];
            TD_REG_DECAY_PERIOD: cfg_in.decay_period = csr_data[TD_TICK_BITS-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drop_margin  <= TD_RST_DROP_MARGIN;
         cfg_ff.count_limit  <= TD_RST_COUNT_LIMIT;
         cfg_ff.on_level     <= TD_RST_ON_LEVEL;
         cfg_ff.off_level    <= TD_RST_OFF_LEVEL;
         cfg_ff.decay_period <= TD_RST_DECAY_PERIOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: sv/td_chan.sv
// One electrode channel: peak tracker, dip counter and touch hysteresis.
`default_nettype none

module td_chan (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire td_pkg::td_step_type     step,
   input  wire td_pkg::td_sample_type   sample,
   input  wire td_pkg::td_cfg_type      cfg,
   output      td_pkg::td_chan_out_type upd
);
   import td_pkg::*;

   localparam int unsigned SUM_BITS = TD_SAMPLE_BITS + 1;

   td_sample_type peak_ff, peak_in;
   td_level_type  cnt_ff, cnt_in;
   logic          flag_ff, flag_in;

   td_sample_type                peak_dec;
   td_sample_type                peak_base;
   logic [SUM_BITS-1:0]          low_sum;
   logic                         dip_hit;
   logic [TD_LEVEL_BITS:0]       cnt_inc;

   // Decay, reload, then climb by one toward the sample
   always_comb begin
      peak_dec  = (step.decay && (peak_ff != '0)) ? td_sample_type'(peak_ff - 1'b1) : peak_ff;
      peak_base = step.reload ? sample : peak_dec;
      peak_in   = (sample > peak_base) ? td_sample_type'(peak_base + 1'b1) : peak_base;
   end

   // Dip test and saturating counter
   always_comb begin
      low_sum = {1'b0, sample}
              + {{(SUM_BITS-TD_MARGIN_BITS){1'b0}}, cfg.drop_margin};
      dip_hit = low_sum < {1'b0, peak_in};
      cnt_inc = {1'b0, cnt_ff} + 1'b1;
      if (dip_hit) begin
         cnt_in = (cnt_inc < {1'b0, cfg.count_limit}) ? cnt_inc[TD_LEVEL_BITS-1:0]
                                                      : cfg.count_limit;
      end else if (cnt_ff != '0) begin
         cnt_in = td_level_type'(cnt_ff - 1'b1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   // Touch flag with hysteresis
   always_comb begin
      priority if (!flag_ff && (cnt_in >= cfg.on_level)) begin
         flag_in = 1'b1;
      end else if (flag_ff && (cnt_in < cfg.off_level)) begin
         flag_in = 1'b0;
      end else begin
         flag_in = flag_ff;
      end
   end

   // Hold state unless a transaction advances
   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
         cnt_ff  <= '0;
         flag_ff <= 1'b0;
      end else if (step.advance) begin
         peak_ff <= peak_in;
         cnt_ff  <= cnt_in;
         flag_ff <= flag_in;
      end
   end

   assign upd.touch = flag_in;
   assign upd.peak  = peak_in;
   assign upd.level = cnt_in;

   // Without a reload the peak moves by at most one step
   a_peak_step: assert property (@(posedge clock) disable iff (reset)
      (step.advance && !step.reload) |->
         ((peak_in == peak_ff) || (peak_in == td_sample_type'(peak_ff + 1'b1))
          || (peak_in == td_sample_type'(peak_ff - 1'b1))))
      else $error("peak moved by more than one step");

   // A dip never leaves the counter above the limit
   a_cnt_limit: assert property (@(posedge clock) disable iff (reset)
      (step.advance && dip_hit) |-> (cnt_in <= cfg.count_limit))
      else $error("dip counter above limit");

   // A non-dip sample never raises the counter
   a_cnt_fall: assert property (@(posedge clock) disable iff (reset)
      (step.advance && !dip_hit) |-> (cnt_in <= cnt_ff))
      else $error("dip counter rose without a dip");

   // Touch only switches on at or above the on level
   a_touch_on: assert property (@(posedge clock) disable iff (reset)
      (step.advance && flag_in && !flag_ff) |-> (cnt_in >= cfg.on_level))
      else $error("touch switched on below on level");

endmodule

`default_nettype wire

FILE: sv/touch_dip_detector_core.sv
// Top level of the touch dip detector: input register, shared control and result register.
`default_nettype none

// Peak-tracking touch detector for two electrodes. Each request transaction
// carries one sample per electrode and a sensor error flag; each one yields
// exactly one response transaction with the touch flags, updated peaks and
// dip counters. One transaction is taken per clock cycle when the response
// side does not stall. The request lands in an input register, the
// per-channel update (decay, reload, climb, dip count, hysteresis) is done
// against the channel state and lands in the result register. The channel
// state update, done combinationally from the input register, sets the rate.
// Configuration writes are taken at any time but must only be issued while
// no transaction is in flight.
module touch_dip_detector_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire td_pkg::td_sample_type    req_sample_a,
   input  wire td_pkg::td_sample_type    req_sample_b,
   input  wire logic                     req_sensor_error,
   // response channel
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic                     rsp_touch_a,
   output      logic                     rsp_touch_b,
   output      td_pkg::td_sample_type    rsp_peak_a,
   output      td_pkg::td_sample_type    rsp_peak_b,
   output      td_pkg::td_level_type     rsp_level_a,
   output      td_pkg::td_level_type     rsp_level_b,
   // configuration channel
   input  wire logic                     csr_valid,
   output      logic                     csr_ready,
   input  wire td_pkg::td_csr_index_type csr_index,
   input  wire td_pkg::td_csr_data_type  csr_data
);
   import td_pkg::*;

   td_cfg_type cfg;

   logic          s1_valid_ff, s1_valid_in;
   td_sample_type s1_sample_ff [TD_MAX_CHANNELS];
   logic          s1_err_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   td_tick_type   tick_ff, tick_in, tick_next;
   logic          reload_ff;

   logic            req_take;
   logic            advance;
   td_step_type     step;
   td_chan_out_type upd [TD_MAX_CHANNELS];
   td_chan_out_type res_ff [TD_MAX_CHANNELS];

   td_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Handshake: move a transaction forward when the result register is free
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Decay tick and per-transaction control
   always_comb begin
      tick_next    = td_tick_type'(tick_ff + 1'b1);
      step.advance = advance;
      step.decay   = (tick_next == cfg.decay_period);
      step.reload  = reload_ff;
      tick_in      = step.decay ? '0 : tick_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tick_ff      <= '0;
         reload_ff    <= 1'b1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            tick_ff   <= tick_in;
            reload_ff <= s1_err_ff;
         end
      end
   end

   // Capture the request payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sample_ff[0] <= req_sample_a;
         s1_sample_ff[1] <= req_sample_b;
         s1_err_ff       <= req_sensor_error;
      end
   end

   // Channel units; unused channels report zero
   for (genvar c = 0; c < TD_MAX_CHANNELS; c++) begin : g_chan
      if (c < TD_CHANNELS) begin : g_used
         td_chan u_chan (
            .clock  (clock),
            .reset  (reset),
            .step   (step),
            .sample (s1_sample_ff[c]),
            .cfg    (cfg),
            .upd    (upd[c])
         );
      end else begin : g_unused
         assign upd[c] = '0;
      end

      // Load the result register; force touch low on error
      always_ff @(posedge clock) begin
         if (advance) begin
            res_ff[c].touch <= upd[c].touch && !s1_err_ff;
            res_ff[c].peak  <= upd[c].peak;
            res_ff[c].level <= upd[c].level;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_touch_a = res_ff[0].touch;
   assign rsp_touch_b = res_ff[1].touch;
   assign rsp_peak_a  = res_ff[0].peak;
   assign rsp_peak_b  = res_ff[1].peak;
   assign rsp_level_a = res_ff[0].level;
   assign rsp_level_b = res_ff[1].level;

   // An error transaction arms a reload for the next one
   a_err_reload: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_err_ff) |=> reload_ff)
      else $error("error did not arm a peak reload");

   // A request is only taken into a full input register when it drains
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_take && s1_valid_ff) |-> advance)
      else $error("input register overwritten");

   // The tick never rests on a nonzero period after a step
   a_tick_wrap: assert property (@(posedge clock) disable iff (reset)
      (advance && (cfg.decay_period != '0)) |=> (tick_ff != $past(cfg.decay_period)))
      else $error("decay tick left on period");

   // A finished result is never replaced while the response side stalls
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !advance)
      else $error("result overwritten while stalled");

endmodule

`default_nettype wire
